// ===== rtl/core/agqz_pkg.sv =====
// shared constants, result type and magnitude helper for the absmax int8 quantiser
package agqz_pkg;

  localparam int GroupSizeDef = 64;
  localparam int SampleW      = 16;
  localparam int AlphaW       = 16;
  localparam int PeakW        = 16;
  localparam int CodeW        = 8;
  localparam int QuotW        = 7;

  localparam logic [AlphaW-1:0] AlphaReset = 16'd16384;
  localparam logic [CodeW-1:0]  CodeLimit  = 8'd127;

  typedef struct packed {
    logic                    done;
    logic signed [CodeW-1:0] code;
  } agqz_result_t;

  // |raw| for a two's complement sample, full negative scale gives 32768
  function automatic logic [PeakW-1:0] magnitude(logic [SampleW-1:0] raw);
    logic [SampleW:0] ext;
    ext = {raw[SampleW-1], raw};
    if (raw[SampleW-1]) begin
      ext = '0 - ext;
    end
    return ext[PeakW-1:0];
  endfunction

endpackage

// ===== rtl/core/agqz_sample_mem.sv =====
// sample store: one write port, one registered read port
module agqz_sample_mem #(
  parameter int Depth = agqz_pkg::GroupSizeDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AddrW-1:0]             wr_addr_i,
  input  logic [agqz_pkg::SampleW-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AddrW-1:0]             rd_addr_i,
  output logic [agqz_pkg::SampleW-1:0] rd_data_o
);

  logic [agqz_pkg::SampleW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/agqz_scale_unit.sv =====
// scaler: multiply, exact rounding prep and iterative divide to one int8 code
module agqz_scale_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [agqz_pkg::SampleW-1:0] sample_i,
  input  logic [agqz_pkg::PeakW-1:0]   peak_i,
  input  logic [agqz_pkg::AlphaW-1:0]  alpha_i,
  input  logic                         ack_i,
  output agqz_pkg::agqz_result_t       result_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SNum  = 3'd1;
  localparam logic [2:0] SPrep = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        neg_q, zero_q, sat_q;
  logic [31:0] prod_q;
  logic [38:0] num_q;
  logic [22:0] rem_q;
  logic [agqz_pkg::QuotW-1:0] quot_q;
  logic [2:0]  step_q;

  logic [40:0] sum_w;
  logic [25:0] m_w;
  logic [22:0] lim_w;
  logic [22:0] trial_w;
  logic [agqz_pkg::CodeW-1:0] mag8_w;

  // (2*num + den) / (2*den) with den = peak << 14, shifted down by 15
  assign sum_w   = {1'b0, num_q, 1'b0} + {11'd0, peak_i, 14'd0};
  assign m_w     = sum_w[40:15];
  assign lim_w   = {peak_i, 7'd0};
  assign trial_w = {7'd0, peak_i} << step_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (start_i) state_d = SNum;
      SNum:    state_d = SPrep;
      SPrep:   state_d = SDiv;
      SDiv:    if (step_q == 3'd0) state_d = SDone;
      SDone:   if (ack_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (start_i) begin
          neg_q  <= sample_i[agqz_pkg::SampleW-1];
          zero_q <= (peak_i == '0);
          prod_q <= agqz_pkg::magnitude(sample_i) * alpha_i;
        end
      end
      SNum: begin
        num_q <= {prod_q, 7'd0} - {7'd0, prod_q};
      end
      SPrep: begin
        sat_q  <= (m_w >= {3'd0, lim_w});
        rem_q  <= m_w[22:0];
        quot_q <= '0;
        step_q <= 3'd6;
      end
      SDiv: begin
        if (rem_q >= trial_w) begin
          rem_q          <= rem_q - trial_w;
          quot_q[step_q] <= 1'b1;
        end
        step_q <= step_q - 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign mag8_w = zero_q ? '0 : (sat_q ? agqz_pkg::CodeLimit : {1'b0, quot_q});

  assign result_o.done = (state_q == SDone);
  assign result_o.code = neg_q ? $signed('0 - mag8_w) : $signed(mag8_w);

endmodule

// ===== rtl/core/absmax_group_int8_quantizer.sv =====
// top level: group collection, sequencing of the scaler and the output register
//
// absmax group int8 quantiser
// - input channel (in_valid_i / in_stall_o) takes one weight sample per transfer,
//   group_last_i closes the group; a group also closes on its GROUP_SIZE-th sample
// - a new sample is accepted every clock while the group is being collected
// - once a group is closed the block emits one code per stored sample in arrival
//   order on the output channel (out_valid_o / out_stall_i), last one flagged
// - each code passes through store read, multiply, scale, rounding prep and the
//   seven steps of the one-bit-per-cycle restoring divider in the scaler
// - the input is stalled while codes are produced; it reopens as soon as the
//   last code sits in the output register, so the next group can load meanwhile
// - a stalled receiver holds the output register and the scaler waits on it
// - alpha_gain (Q2.14) is written through the cfg channel, always ready; write
//   it only while the block is idle
// - reset clears the control state, the fill count and the peak, and loads alpha
//   with 1.0; the sample store is not cleared
module absmax_group_int8_quantizer #(
  parameter int GROUP_SIZE = agqz_pkg::GroupSizeDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [agqz_pkg::AlphaW-1:0]        cfg_alpha_gain_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [agqz_pkg::SampleW-1:0] weight_sample_i,
  input  logic                               group_last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [agqz_pkg::CodeW-1:0]  quant_code_o,
  output logic                               code_last_o
);

  localparam int IdxW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int CntW = $clog2(GROUP_SIZE + 1);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StStart = 2'd2;
  localparam logic [1:0] StWait  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             total_q, total_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [agqz_pkg::PeakW-1:0]  peak_q, peak_d;
  logic [agqz_pkg::AlphaW-1:0] alpha_q;

  logic                        out_valid_q, out_valid_d;
  logic signed [agqz_pkg::CodeW-1:0] code_q;
  logic                        last_q;

  logic                        in_xfer, out_free, out_load, code_is_last;
  logic [CntW-1:0]             fill_inc;
  logic [agqz_pkg::PeakW-1:0]  in_mag;
  logic [agqz_pkg::SampleW-1:0] rd_data;
  agqz_pkg::agqz_result_t      result;

  // configuration: single register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= agqz_pkg::AlphaReset;
    end else if (cfg_valid_i) begin
      alpha_q <= cfg_alpha_gain_i;
    end
  end

  // collection side
  assign in_stall_o   = (state_q != StLoad);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign fill_inc     = fill_q + 1'b1;
  assign in_mag       = agqz_pkg::magnitude(weight_sample_i);

  // emission side
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_load     = (state_q == StWait) && result.done && out_free;
  assign code_is_last = ((CntW'(idx_q) + 1'b1) == total_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    idx_d       = idx_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StLoad: begin
        if (in_xfer) begin
          fill_d = fill_inc;
          if (in_mag > peak_q) begin
            peak_d = in_mag;
          end
          // group closes on the marker or when the store is full
          if (group_last_i || (fill_inc == CntW'(GROUP_SIZE))) begin
            total_d = fill_inc;
            idx_d   = '0;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StStart;
      end
      StStart: begin
        state_d = StWait;
      end
      StWait: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (code_is_last) begin
            fill_d  = '0;
            peak_d  = '0;
            state_d = StLoad;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      fill_q      <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register, loaded only on a free slot
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      code_q <= result.code;
      last_q <= code_is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quant_code_o = code_q;
  assign code_last_o  = last_q;

  agqz_sample_mem #(
    .Depth (GROUP_SIZE),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_xfer),
    .wr_addr_i (fill_q[IdxW-1:0]),
    .wr_data_i (weight_sample_i),
    .rd_en_i   (state_q == StRead),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  agqz_scale_unit u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == StStart),
    .sample_i (rd_data),
    .peak_i   (peak_q),
    .alpha_i  (alpha_q),
    .ack_i    (out_load),
    .result_o (result)
  );

  // a code never takes the unused most negative value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quant_code_o != -8'sd128))
    else $error("code outside saturation range");

  // the fill count never runs past the group size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(GROUP_SIZE))
    else $error("fill count beyond group size");

  // while codes are produced the group is not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (fill_q != '0) && (total_q != '0))
    else $error("emission with empty group");

  // the scaler is only started when it has no result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStart) |-> !result.done)
    else $error("scaler restarted with result pending");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the absmax group int8 quantiser, with its own code predictor
module testbench;

  import agqz_pkg::*;

  localparam int          GroupLen     = GroupSizeDef;
  localparam logic [15:0] OneQ14       = 16'd16384;
  // ample room after the last code for the scaler to go quiet
  localparam int          SettleCycles = 40;
  localparam int          CycleLimit   = 300000;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } weight_item_t;

  // dut ports, all inputs start at a known value
  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      cfg_valid_i      = 1'b0;
  logic                      cfg_ready_o;
  logic [AlphaW-1:0]         cfg_alpha_gain_i = '0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] weight_sample_i  = '0;
  logic                      group_last_i     = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic signed [CodeW-1:0]   quant_code_o;
  logic                      code_last_o;

  // predictor state: gain register, group buffer, running peak and fill level
  logic [AlphaW-1:0]  gain_q14 = AlphaReset;
  logic [SampleW-1:0] group_buf [GroupLen];
  logic [PeakW-1:0]   group_peak = '0;
  int                 group_fill = 0;

  // samples waiting for the driver, codes waiting for the monitor
  weight_item_t sample_queue [$];
  agqz_result_t code_queue [$];
  weight_item_t next_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int samples_queued = 0;
  int samples_taken  = 0;
  int groups_closed  = 0;
  int codes_checked  = 0;
  int gain_writes    = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  absmax_group_int8_quantizer #(
    .GROUP_SIZE(GroupLen)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_alpha_gain_i (cfg_alpha_gain_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .weight_sample_i  (weight_sample_i),
    .group_last_i     (group_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .quant_code_o     (quant_code_o),
    .code_last_o      (code_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // |raw| on 17 bits, so the negative full scale comes out as 32768
  function automatic logic [16:0] abs_sample(logic [SampleW-1:0] raw);
    return raw[SampleW-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
  endfunction

  // round(|raw| * 127 * gain / peak) half away from zero, clipped to 127, sign put back
  function automatic logic signed [CodeW-1:0] scaled_code(logic [SampleW-1:0] raw);
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      quot;
    logic [CodeW-1:0] code;
    if (group_peak == '0) begin
      return '0;
    end
    num  = 64'(abs_sample(raw)) * 64'(CodeLimit) * 64'(gain_q14);
    den  = 64'(group_peak) * 64'(OneQ14);
    quot = (2 * num + den) / (2 * den);
    if (quot > 64'(CodeLimit)) begin
      quot = 64'(CodeLimit);
    end
    code = quot[CodeW-1:0];
    if (raw[SampleW-1]) begin
      code = -code;
    end
    return code;
  endfunction

  // one accepted sample: store it, track the peak, and on a closed group queue all its codes
  task automatic take_sample(logic [SampleW-1:0] raw, logic last);
    logic [16:0]  mag;
    agqz_result_t res;
    mag = abs_sample(raw);
    group_buf[group_fill] = raw;
    group_fill++;
    if (mag > 17'(group_peak)) begin
      group_peak = mag[PeakW-1:0];
    end
    // a full buffer closes the group even without the last marker
    if (last || group_fill == GroupLen) begin
      for (int k = 0; k < group_fill; k++) begin
        res.code = scaled_code(group_buf[k]);
        res.done = (k == group_fill - 1);
        code_queue.push_back(res);
      end
      group_fill = 0;
      group_peak = '0;
      groups_closed++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item per transfer, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      weight_sample_i <= '0;
      group_last_i    <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_sample(weight_sample_i, group_last_i);
        samples_taken++;
      end
      // new item or gap only once the current one has gone
      if (!in_valid_i || !in_stall_o) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item        = sample_queue.pop_front();
          in_valid_i      <= 1'b1;
          weight_sample_i <= next_item.sample;
          group_last_i    <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, compare every code transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    agqz_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (code_queue.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected code %0d last %0b at cycle %0d",
                     quant_code_o, code_last_o, cycle_count);
          end
          error_count++;
        end else begin
          want = code_queue.pop_front();
          codes_checked++;
          if (want.code !== quant_code_o || want.done !== code_last_o) begin
            if (error_count < 10) begin
              $display("code mismatch at cycle %0d: expected %0d last %0b, got %0d last %0b",
                       cycle_count, want.code, want.done, quant_code_o, code_last_o);
            end
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes still outstanding",
               cycle_count, code_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic set_idle(int send_pct, int stall_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // gain write, only ever issued from a quiet block once the run before it has drained
  task automatic write_gain(logic [AlphaW-1:0] value);
    cfg_alpha_gain_i <= value;
    cfg_valid_i      <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gain_q14 = value;
    gain_writes++;
  endtask

  // extremes, tiny values and full random patterns in a mix
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(15));
      3:       return -16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [SampleW-1:0] sample, logic last);
    weight_item_t item;
    item.sample = sample;
    item.last   = last;
    sample_queue.push_back(item);
    samples_queued++;
  endtask

  // one group of len samples; without close, a full-length group ends when the store is full
  task automatic add_group(int len, bit close);
    bit zeros;
    zeros = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      push_item(zeros ? '0 : pick_sample(), close && (i == len - 1));
    end
  endtask

  // short groups until about budget samples are queued, always ending on a closed group
  task automatic fill_random(int budget);
    int start;
    start = samples_queued;
    while (samples_queued - start < budget) begin
      add_group($urandom_range(8, 1), 1'b1);
    end
  endtask

  // wait until every sample has gone in and every code has come out, then let it settle
  task automatic drain();
    while (samples_taken != samples_queued || code_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    weight_item_t directed_set [22];
    directed_set = '{
      // all-zero group gives all-zero codes
      '{16'h0000, 1'b0}, '{16'h0000, 1'b0}, '{16'h0000, 1'b1},
      // single sample group at positive full scale
      '{16'h7FFF, 1'b1},
      // negative full scale as the peak, mixed with the positive extreme
      '{16'h8000, 1'b0}, '{16'h7FFF, 1'b0}, '{16'h0001, 1'b0},
      '{16'hFFFF, 1'b0}, '{16'h4000, 1'b0}, '{16'hC000, 1'b1},
      // peak 254 puts odd samples exactly on a half
      '{16'd254, 1'b0}, '{16'd1, 1'b0}, '{-16'd1, 1'b0},
      '{16'd3, 1'b0}, '{-16'd3, 1'b0}, '{16'd127, 1'b1},
      // lone negative full scale
      '{16'h8000, 1'b1},
      // unit peak
      '{16'h0001, 1'b0}, '{16'h0000, 1'b0}, '{16'hFFFF, 1'b1},
      // alternating bit patterns
      '{16'h5555, 1'b0}, '{16'hAAAA, 1'b1}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset gain, no idling
    set_idle(0, 0);
    foreach (directed_set[i]) begin
      push_item(directed_set[i].sample, directed_set[i].last);
    end
    drain();

    // largest gain, saturating codes, starting with a group that fills up without a marker
    write_gain(16'hFFFF);
    set_idle(0, 0);
    add_group(GroupLen, 1'b0);
    fill_random(1);
    drain();

    // zero gain, sender idling
    write_gain(16'h0000);
    set_idle(55, 0);
    fill_random(3);
    drain();

    // random gain, receiver stalling
    write_gain(16'($urandom));
    set_idle(0, 55);
    fill_random(3);
    drain();

    // half gain, both sides idling a little
    write_gain(16'd8192);
    set_idle(10, 10);
    fill_random(1);
    drain();

    // back to unity gain with a steady stream
    write_gain(OneQ14);
    set_idle(0, 0);
    fill_random(1);
    drain();

    if (code_queue.size() != 0) begin
      $display("%0d predicted codes never arrived", code_queue.size());
      error_count += code_queue.size();
    end

    $display("run covered %0d samples in %0d groups over %0d gain settings",
             samples_taken, groups_closed, gain_writes + 1);
    $display("%0d codes checked, %0d errors", codes_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
